@@ rtl/srmb_pkg.sv @@
package srmb_pkg;

  localparam int SCREEN_W_DEF   = 480;
  localparam int SCREEN_H_DEF   = 272;
  localparam int MAX_SPRITE_DEF = 256;
  localparam int ANGLE_STEPS    = 360;

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 11;
  localparam int ANCHOR_W     = 11;
  localparam int SIZE_REG_W   = 9;
  localparam int ANGLE_W      = 10;
  localparam int FRAME_ADDR_W = 17;
  localparam int TRIG_W       = 16;
  localparam int Q14_SHIFT    = 14;

  localparam logic signed [TRIG_W-1:0] Q14_ONE = 16'sd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANCHOR_X = 3'd0,
    CFG_ANCHOR_Y = 3'd1,
    CFG_SPRITE_W = 3'd2,
    CFG_SPRITE_H = 3'd3,
    CFG_ANGLE    = 3'd4,
    CFG_MIRROR   = 3'd5
  } cfg_idx_t;

  // Pixel payload carried down the pipeline: ABGR word and end-of-sprite flag.
  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } pix_t;

  localparam logic [8:0] DEG_90  = 9'd90;
  localparam logic [8:0] DEG_180 = 9'd180;
  localparam logic [8:0] DEG_270 = 9'd270;
  localparam logic [8:0] DEG_360 = 9'(ANGLE_STEPS);

  localparam logic signed [ANGLE_W:0] ANG_WRAP = 11'sd360;

  // round(16384 * sin(d)) for d = 0..90 degrees
  localparam logic [14:0] QUARTER_SINE [91] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15667, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16321, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // Fold a signed angle register into 0..359.
  function automatic logic [8:0] angle_reduce(input logic [ANGLE_W-1:0] a);
    logic signed [ANGLE_W:0] v;
    v = $signed({a[ANGLE_W-1], a});
    if (v < 0) begin
      v = v + ANG_WRAP;
      if (v < 0) begin
        v = v + ANG_WRAP;
      end
    end else if (v >= ANG_WRAP) begin
      v = v - ANG_WRAP;
    end
    return v[8:0];
  endfunction

  function automatic logic [8:0] cos_index(input logic [8:0] d);
    logic [9:0] e;
    e = {1'b0, d} + {1'b0, DEG_90};
    if (e >= {1'b0, DEG_360}) begin
      e = e - {1'b0, DEG_360};
    end
    return e[8:0];
  endfunction

  function automatic logic signed [TRIG_W-1:0] sine_q14(input logic [8:0] d);
    logic [6:0]  idx;
    logic        neg;
    logic [14:0] mag;
    if (d <= DEG_90) begin
      idx = d[6:0];
      neg = 1'b0;
    end else if (d <= DEG_180) begin
      idx = 7'(DEG_180 - d);
      neg = 1'b0;
    end else if (d <= DEG_270) begin
      idx = 7'(d - DEG_180);
      neg = 1'b1;
    end else begin
      idx = 7'(DEG_360 - d);
      neg = 1'b1;
    end
    mag = QUARTER_SINE[idx];
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

@@ rtl/srmb_cfg.sv @@
module srmb_cfg
  import srmb_pkg::*;
#(
  parameter int MAX_SPRITE = MAX_SPRITE_DEF,
  localparam int CW = $clog2(MAX_SPRITE),
  localparam int SW = $clog2(MAX_SPRITE + 1),
  localparam int RW = CW + 5,
  localparam int PW = ((RW > ANCHOR_W) ? RW : ANCHOR_W) + 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  output logic                     clr,
  output logic [SW-1:0]            w,
  output logic [SW-1:0]            h,
  output logic                     mirror,
  output logic                     rot,
  output logic signed [TRIG_W-1:0] sin_q14,
  output logic signed [TRIG_W-1:0] cos_q14,
  output logic signed [PW-1:0]     ox_un,
  output logic signed [PW-1:0]     oy_un,
  output logic signed [PW-1:0]     ox_rot,
  output logic signed [PW-1:0]     oy_rot
);

  logic [ANCHOR_W-1:0]      ax_r, ax_nxt, ay_r, ay_nxt;
  logic [SW-1:0]            w_r, w_nxt, h_r, h_nxt;
  logic                     mirror_r, mirror_nxt, rot_r, rot_nxt;
  logic signed [TRIG_W-1:0] sin_r, sin_nxt, cos_r, cos_nxt;
  logic [ANGLE_W-1:0]       ang;
  logic [8:0]               deg;
  logic [PW-1:0]            ax_e, ay_e, w_e, h_e;

  // Clamp a size register into 1..MAX_SPRITE.
  function automatic logic [SW-1:0] eff_size(input logic [SIZE_REG_W-1:0] s);
    if (s == '0) begin
      return SW'(1);
    end else if (32'(s) > 32'(MAX_SPRITE)) begin
      return SW'(MAX_SPRITE);
    end
    return SW'(s);
  endfunction

  assign cfg_ready = 1'b1;

  always_comb begin
    ax_nxt     = ax_r;
    ay_nxt     = ay_r;
    w_nxt      = w_r;
    h_nxt      = h_r;
    mirror_nxt = mirror_r;
    rot_nxt    = rot_r;
    sin_nxt    = sin_r;
    cos_nxt    = cos_r;
    clr        = 1'b0;
    ang        = cfg_wdata[ANGLE_W-1:0];
    deg        = angle_reduce(ang);
    if (cfg_valid) begin
      clr = 1'b1;
      case (cfg_idx_t'(cfg_index))
        CFG_ANCHOR_X: ax_nxt     = cfg_wdata[ANCHOR_W-1:0];
        CFG_ANCHOR_Y: ay_nxt     = cfg_wdata[ANCHOR_W-1:0];
        CFG_SPRITE_W: w_nxt      = eff_size(cfg_wdata[SIZE_REG_W-1:0]);
        CFG_SPRITE_H: h_nxt      = eff_size(cfg_wdata[SIZE_REG_W-1:0]);
        CFG_ANGLE: begin
          rot_nxt = (ang != '0);
          sin_nxt = sine_q14(deg);
          cos_nxt = sine_q14(cos_index(deg));
        end
        CFG_MIRROR:   mirror_nxt = cfg_wdata[0];
        default:      clr        = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r     <= '0;
      ay_r     <= '0;
      w_r      <= SW'(1);
      h_r      <= SW'(1);
      mirror_r <= 1'b0;
      rot_r    <= 1'b0;
      sin_r    <= '0;
      cos_r    <= Q14_ONE;
    end else begin
      ax_r     <= ax_nxt;
      ay_r     <= ay_nxt;
      w_r      <= w_nxt;
      h_r      <= h_nxt;
      mirror_r <= mirror_nxt;
      rot_r    <= rot_nxt;
      sin_r    <= sin_nxt;
      cos_r    <= cos_nxt;
    end
  end

  always_comb begin
    ax_e   = {{(PW-ANCHOR_W){ax_r[ANCHOR_W-1]}}, ax_r};
    ay_e   = {{(PW-ANCHOR_W){ay_r[ANCHOR_W-1]}}, ay_r};
    w_e    = {{(PW-SW){1'b0}}, w_r};
    h_e    = {{(PW-SW){1'b0}}, h_r};
    ox_un  = $signed(ax_e - (w_e >> 1));
    oy_un  = $signed(ay_e - h_e);
    ox_rot = $signed(ax_e);
    oy_rot = $signed(ay_e - h_e + (h_e >> 1));
  end

  assign w       = w_r;
  assign h       = h_r;
  assign mirror  = mirror_r;
  assign rot     = rot_r;
  assign sin_q14 = sin_r;
  assign cos_q14 = cos_r;

endmodule

@@ rtl/srmb_rot.sv @@
module srmb_rot
  import srmb_pkg::*;
#(
  parameter int MAX_SPRITE = MAX_SPRITE_DEF,
  localparam int CW = $clog2(MAX_SPRITE),
  localparam int SW = $clog2(MAX_SPRITE + 1),
  localparam int DW = CW + 1,
  localparam int RW = CW + 5,
  localparam int PW = ((RW > ANCHOR_W) ? RW : ANCHOR_W) + 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CW-1:0]            in_col,
  input  logic [CW-1:0]            in_row,
  input  pix_t                     in_pix,
  input  logic [SW-1:0]            w,
  input  logic [SW-1:0]            h,
  input  logic                     mirror,
  input  logic signed [TRIG_W-1:0] sin_q14,
  input  logic signed [TRIG_W-1:0] cos_q14,
  input  logic signed [PW-1:0]     ox_un,
  input  logic signed [PW-1:0]     oy_un,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [RW-1:0]     out_rx,
  output logic signed [RW-1:0]     out_ry,
  output logic signed [PW-1:0]     out_ux,
  output logic signed [PW-1:0]     out_uy,
  output pix_t                     out_pix
);

  localparam int PRW = DW + TRIG_W;
  localparam int SMW = PRW + 1;
  localparam logic [SMW-1:0] Q14_HALF = SMW'(1) << (Q14_SHIFT - 1);

  logic                  rdy1, rdy2;
  logic                  v1_r, v2_r;
  logic signed [DW-1:0]  dx, dy;
  logic [SW-1:0]         offs;
  logic signed [PRW-1:0] pxc_nxt, pys_nxt, pyc_nxt, pxs_nxt;
  logic signed [PRW-1:0] pxc_r, pys_r, pyc_r, pxs_r;
  logic signed [PW-1:0]  ux_nxt, uy_nxt, ux1_r, uy1_r, ux2_r, uy2_r;
  logic signed [SMW-1:0] rx_sum, ry_sum;
  logic signed [RW-1:0]  rx_r, ry_r;
  pix_t                  pix1_r, pix2_r;

  // Divide by 2^14, rounding half away from zero.
  function automatic logic signed [RW-1:0] round_q14(input logic signed [SMW-1:0] v);
    logic [SMW-1:0]       mag;
    logic [SMW-1:0]       q;
    logic signed [RW-1:0] qs;
    mag = v[SMW-1] ? SMW'(-v) : SMW'(v);
    q   = (mag + Q14_HALF) >> Q14_SHIFT;
    qs  = $signed(RW'(q));
    return v[SMW-1] ? -qs : qs;
  endfunction

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    dx      = $signed({1'b0, in_col}) - $signed(DW'(w >> 1));
    dy      = $signed({1'b0, in_row}) - $signed(DW'(h >> 1));
    pxc_nxt = dx * cos_q14;
    pys_nxt = dy * sin_q14;
    pyc_nxt = dy * cos_q14;
    pxs_nxt = dx * sin_q14;
    offs    = mirror ? (w - SW'(1) - SW'(in_col)) : SW'(in_col);
    ux_nxt  = ox_un + $signed({{(PW-SW){1'b0}}, offs});
    uy_nxt  = oy_un + $signed({{(PW-CW){1'b0}}, in_row});
  end

  always_comb begin
    rx_sum = $signed({pxc_r[PRW-1], pxc_r}) + $signed({pys_r[PRW-1], pys_r});
    ry_sum = $signed({pyc_r[PRW-1], pyc_r}) - $signed({pxs_r[PRW-1], pxs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      pxc_r  <= pxc_nxt;
      pys_r  <= pys_nxt;
      pyc_r  <= pyc_nxt;
      pxs_r  <= pxs_nxt;
      ux1_r  <= ux_nxt;
      uy1_r  <= uy_nxt;
      pix1_r <= in_pix;
    end
    if (rdy2) begin
      rx_r   <= round_q14(rx_sum);
      ry_r   <= round_q14(ry_sum);
      ux2_r  <= ux1_r;
      uy2_r  <= uy1_r;
      pix2_r <= pix1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_rx    = rx_r;
  assign out_ry    = ry_r;
  assign out_ux    = ux2_r;
  assign out_uy    = uy2_r;
  assign out_pix   = pix2_r;

endmodule

@@ rtl/srmb_place.sv @@
module srmb_place
  import srmb_pkg::*;
#(
  parameter int SCREEN_W   = SCREEN_W_DEF,
  parameter int SCREEN_H   = SCREEN_H_DEF,
  parameter int MAX_SPRITE = MAX_SPRITE_DEF,
  localparam int CW = $clog2(MAX_SPRITE),
  localparam int RW = CW + 5,
  localparam int PW = ((RW > ANCHOR_W) ? RW : ANCHOR_W) + 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [RW-1:0]    in_rx,
  input  logic signed [RW-1:0]    in_ry,
  input  logic signed [PW-1:0]    in_ux,
  input  logic signed [PW-1:0]    in_uy,
  input  pix_t                    in_pix,
  input  logic                    rot,
  input  logic signed [PW-1:0]    ox_rot,
  input  logic signed [PW-1:0]    oy_rot,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [FRAME_ADDR_W-1:0] out_frame_address,
  output logic [31:0]             out_pixel_word,
  output logic                    out_last_pixel
);

  localparam int CXW = $clog2(SCREEN_W);
  localparam int RYW = $clog2(SCREEN_H);
  localparam int AW  = $clog2(SCREEN_W * SCREEN_H);

  logic                    rdy3, rdy_out;
  logic                    v3_r, vis3_r, out_valid_r;
  logic signed [PW-1:0]    px, py;
  logic                    on_x, on_y, vis_nxt;
  logic [CXW-1:0]          col3_r;
  logic [RYW-1:0]          row3_r;
  pix_t                    pix3_r;
  logic [AW-1:0]           addr;
  logic [FRAME_ADDR_W-1:0] addr_r;
  logic [31:0]             word_r;
  logic                    last_r;

  assign rdy_out  = !out_valid_r || out_ready;
  assign rdy3     = !v3_r || rdy_out;
  assign in_ready = rdy3;

  always_comb begin
    px      = rot ? ox_rot + $signed({{(PW-RW){in_rx[RW-1]}}, in_rx}) : in_ux;
    py      = rot ? oy_rot + $signed({{(PW-RW){in_ry[RW-1]}}, in_ry}) : in_uy;
    on_x    = !px[PW-1] && (px[PW-2:0] < (PW-1)'(SCREEN_W));
    on_y    = !py[PW-1] && (py[PW-2:0] < (PW-1)'(SCREEN_H));
    vis_nxt = (in_pix.word[31:24] != 8'd0) && on_x && on_y;
  end

  always_comb begin
    addr = AW'(col3_r) + AW'(row3_r) * AW'(SCREEN_W);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy3) begin
        v3_r <= in_valid;
      end
      if (rdy_out) begin
        out_valid_r <= v3_r && vis3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      vis3_r <= vis_nxt;
      col3_r <= px[CXW-1:0];
      row3_r <= py[RYW-1:0];
      pix3_r <= in_pix;
    end
    if (rdy_out) begin
      addr_r <= FRAME_ADDR_W'(addr);
      word_r <= pix3_r.word;
      last_r <= pix3_r.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_address = addr_r;
  assign out_pixel_word    = word_r;
  assign out_last_pixel    = last_r;

endmodule

@@ rtl/sprite_rotate_mirror_blit.sv @@
// The path runs through the input register, the product stage, the rounding stage,
//   the placement stage, then the output register.
// Throughput: one pixel per cycle; each stage holds only while the one after it is full.
// Reset: synchronous, active low; empties the pipeline, zeroes the column and row
//   counters and loads the register defaults (size 1x1, angle 0, no mirror).
module sprite_rotate_mirror_blit
  import srmb_pkg::*;
#(
  parameter int SCREEN_W   = SCREEN_W_DEF,
  parameter int SCREEN_H   = SCREEN_H_DEF,
  parameter int MAX_SPRITE = MAX_SPRITE_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_red,
  input  logic [7:0]              in_green,
  input  logic [7:0]              in_blue,
  input  logic [7:0]              in_alpha,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [FRAME_ADDR_W-1:0] out_frame_address,
  output logic [31:0]             out_pixel_word,
  output logic                    out_last_pixel,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CW = $clog2(MAX_SPRITE);
  localparam int SW = $clog2(MAX_SPRITE + 1);
  localparam int RW = CW + 5;
  localparam int PW = ((RW > ANCHOR_W) ? RW : ANCHOR_W) + 2;

  // Configuration outputs
  logic                     cnt_clr;
  logic [SW-1:0]            w, h;
  logic                     mirror, rot;
  logic signed [TRIG_W-1:0] sin_q14, cos_q14;
  logic signed [PW-1:0]     ox_un, oy_un, ox_rot, oy_rot;

  // Raster position counters and the input register
  logic [CW-1:0] col_cnt_r, col_cnt_nxt, row_cnt_r, row_cnt_nxt;
  logic          col_end, row_end, in_xfer;
  logic          v0_r;
  logic [CW-1:0] col0_r, row0_r;
  pix_t          pix0_r;

  // Rotation to placement
  logic                 rot_in_ready;
  logic                 rot_valid, place_ready;
  logic signed [RW-1:0] rx, ry;
  logic signed [PW-1:0] ux, uy;
  pix_t                 rot_pix;

  srmb_cfg #(
    .MAX_SPRITE(MAX_SPRITE)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .clr      (cnt_clr),
    .w        (w),
    .h        (h),
    .mirror   (mirror),
    .rot      (rot),
    .sin_q14  (sin_q14),
    .cos_q14  (cos_q14),
    .ox_un    (ox_un),
    .oy_un    (oy_un),
    .ox_rot   (ox_rot),
    .oy_rot   (oy_rot)
  );

  // The input register frees up whenever the rotation stage can take its item.
  assign in_ready = !v0_r || rot_in_ready;
  assign in_xfer  = in_valid && in_ready;

  // Advance the raster position on every transfer, whether or not the pixel
  // is later dropped; wrap at the end of the row and at the end of the sprite.
  // Any accepted write to a defined register restarts the sprite at its top-left pixel.
  always_comb begin
    col_end     = (SW'(col_cnt_r) == w - SW'(1));
    row_end     = (SW'(row_cnt_r) == h - SW'(1));
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (cnt_clr) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end else if (in_xfer) begin
      if (col_end) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = row_end ? '0 : row_cnt_r + CW'(1);
      end else begin
        col_cnt_nxt = col_cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      v0_r      <= 1'b0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
      if (in_ready) begin
        v0_r <= in_valid;
      end
    end
  end

  // Capture the pixel repacked as ABGR, tagged with its sprite position.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      col0_r      <= col_cnt_r;
      row0_r      <= row_cnt_r;
      pix0_r.word <= {in_alpha, in_blue, in_green, in_red};
      pix0_r.last <= col_end && row_end;
    end
  end

  // Two stages: the four Q14 products, then the rounded rotated offsets.
  // The unrotated position travels alongside.
  srmb_rot #(
    .MAX_SPRITE(MAX_SPRITE)
  ) u_rot (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v0_r),
    .in_ready (rot_in_ready),
    .in_col   (col0_r),
    .in_row   (row0_r),
    .in_pix   (pix0_r),
    .w        (w),
    .h        (h),
    .mirror   (mirror),
    .sin_q14  (sin_q14),
    .cos_q14  (cos_q14),
    .ox_un    (ox_un),
    .oy_un    (oy_un),
    .out_valid(rot_valid),
    .out_ready(place_ready),
    .out_rx   (rx),
    .out_ry   (ry),
    .out_ux   (ux),
    .out_uy   (uy),
    .out_pix  (rot_pix)
  );

  // Select the screen position, drop transparent and off-screen pixels,
  // form the frame-buffer address and hold the result for the consumer.
  srmb_place #(
    .SCREEN_W  (SCREEN_W),
    .SCREEN_H  (SCREEN_H),
    .MAX_SPRITE(MAX_SPRITE)
  ) u_place (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (rot_valid),
    .in_ready         (place_ready),
    .in_rx            (rx),
    .in_ry            (ry),
    .in_ux            (ux),
    .in_uy            (uy),
    .in_pix           (rot_pix),
    .rot              (rot),
    .ox_rot           (ox_rot),
    .oy_rot           (oy_rot),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_address(out_frame_address),
    .out_pixel_word   (out_pixel_word),
    .out_last_pixel   (out_last_pixel)
  );

endmodule

@@ rtl/srmb_checker.sv @@
module srmb_checker
  import srmb_pkg::*;
#(
  parameter int SCREEN_W = SCREEN_W_DEF,
  parameter int SCREEN_H = SCREEN_H_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [FRAME_ADDR_W-1:0] out_frame_address,
  input logic [31:0]             out_pixel_word,
  input logic                    out_last_pixel
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_address) &&
      $stable(out_pixel_word) && $stable(out_last_pixel))
    else $error("result changed while stalled");

  // Only on-screen positions reach the output.
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({15'd0, out_frame_address} < 32'(SCREEN_W * SCREEN_H)))
    else $error("frame address beyond the screen");

  // Transparent pixels never reach the output.
  a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel_word[31:24] != 8'd0))
    else $error("transparent pixel delivered");

  // Reset leaves the pipeline empty and open for input.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind sprite_rotate_mirror_blit srmb_checker #(
  .SCREEN_W(SCREEN_W),
  .SCREEN_H(SCREEN_H)
) u_srmb_checker (.*);
